// ===== design/mlfq_pkg.sv =====
// Shared types and constants for the MLFQ process table.
// Holds the transfer payload structs, operation and result codes and reset values.
// No dependencies.
package mlfq_pkg;

  localparam int DEF_NUM_SLOTS  = 16;
  localparam int DEF_NUM_LEVELS = 5;

  localparam int PID_W   = 16;
  localparam int LVL_W   = 3;
  localparam int STAT_W  = 3;
  localparam int QU_W    = 20;
  localparam int RP_W    = 40;
  localparam int TIME_W  = 48;
  localparam int RT_W    = 24;
  localparam int GSLOT_W = 4;
  // Largest quantum is 8 units of a 20-bit unit, which fits in 23 bits.
  localparam int REM_W   = QU_W + 3;

  localparam int CFG_W     = RP_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUANTUM_UNIT   = 2'd0,
    CFG_RESET_PERIOD   = 2'd1,
    CFG_SHELL_PID      = 2'd2,
    CFG_FIRST_USER_PID = 2'd3
  } cfg_idx_e;

  localparam logic [QU_W-1:0]  QU_RST    = 20'd100000;
  localparam logic [RP_W-1:0]  RP_RST    = 40'd10000000;
  localparam logic [PID_W-1:0] SHELL_RST = 16'd4;
  localparam logic [PID_W-1:0] FUP_RST   = 16'd5;

  typedef enum logic [2:0] {
    OP_ALLOC    = 3'd0,
    OP_CHARGE   = 3'd1,
    OP_SET      = 3'd2,
    OP_FREE     = 3'd3,
    OP_FREE_ALL = 3'd4,
    OP_MAINT    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    RC_OK        = 2'd0,
    RC_FULL      = 2'd1,
    RC_NOT_FOUND = 2'd2
  } rc_e;

  localparam logic [STAT_W-1:0] ST_UNUSED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOADING = 3'd1;

  typedef struct packed {
    logic [2:0]        operation;
    logic [PID_W-1:0]  target_pid;
    logic [3:0]        slot_index;
    logic [STAT_W-1:0] new_status;
    logic [RT_W-1:0]   runtime_us;
    logic [TIME_W-1:0] now_us;
    logic              tty_pending;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_code;
    logic [PID_W-1:0]   given_pid;
    logic [GSLOT_W-1:0] given_slot;
    logic [LVL_W-1:0]   slot_level;
  } out_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] state;
    logic [PID_W-1:0]  pid;
    logic [LVL_W-1:0]  level;
  } row_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;
    logic prep;
    logic rd_en;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic sweep_none;
    logic sweep_one;
  } dp_stat_t;

endpackage

// ===== design/mlfq_ctrl.sv =====
// Controller for the MLFQ process table: sequences prep, slot sweep and result load.
// Depends on mlfq_pkg.
module mlfq_ctrl #(
  parameter int NUM_SLOTS = mlfq_pkg::DEF_NUM_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  mlfq_pkg::dp_stat_t             stat,
  output mlfq_pkg::dp_cmd_t              cmd,
  output logic [$clog2(NUM_SLOTS)-1:0]   sweep_idx
);
  import mlfq_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_SWEEP  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = stat.sweep_none ? S_FINISH : S_SWEEP;
      end
      S_SWEEP: begin
        cmd.rd_en = 1'b1;
        if (stat.sweep_one || cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // The result register is free once its previous transfer completes.
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sweep_idx = cnt_r;
  assign out_valid = out_valid_r;

endmodule

// ===== design/mlfq_dp.sv =====
// Datapath for the MLFQ process table: slot memories, configuration registers,
// per-slot update logic and the result register. Depends on mlfq_pkg.
module mlfq_dp #(
  parameter int NUM_SLOTS  = mlfq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlfq_pkg::CFG_W-1:0]           cfg_wdata,
  input  mlfq_pkg::in_item_t                   in_data,
  output mlfq_pkg::out_item_t                  out_data,
  input  mlfq_pkg::dp_cmd_t                    cmd,
  input  logic [$clog2(NUM_SLOTS)-1:0]         sweep_idx,
  output mlfq_pkg::dp_stat_t                   stat
);
  import mlfq_pkg::*;

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(NUM_LEVELS - 1);

  // Configuration registers.
  logic [QU_W-1:0]  quantum_unit_r;
  logic [RP_W-1:0]  reset_period_r;
  logic [PID_W-1:0] shell_pid_r;
  logic [PID_W-1:0] first_user_pid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_unit_r   <= QU_RST;
      reset_period_r   <= RP_RST;
      shell_pid_r      <= SHELL_RST;
      first_user_pid_r <= FUP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUANTUM_UNIT:   quantum_unit_r   <= cfg_wdata[QU_W-1:0];
        CFG_RESET_PERIOD:   reset_period_r   <= cfg_wdata[RP_W-1:0];
        CFG_SHELL_PID:      shell_pid_r      <= cfg_wdata[PID_W-1:0];
        CFG_FIRST_USER_PID: first_user_pid_r <= cfg_wdata[PID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Slot storage. A row whose valid bit is clear reads as all zeros.
  row_t             rows_mem [NUM_SLOTS];
  logic [REM_W-1:0] rem_mem  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] row_vld_r;

  in_item_t          item_r;
  logic [PID_W-1:0]  pid_counter_r;
  logic [TIME_W-1:0] last_reset_r;
  logic              do_reset_r;
  logic              hit_r;
  logic              shell_done_r;
  logic [LVL_W-1:0]  res_level_r;
  logic [GSLOT_W-1:0] res_slot_r;
  out_item_t         out_data_r;

  logic [SLOT_W-1:0] rd_addr;
  row_t              rd_row_r;
  logic [REM_W-1:0]  rd_rem_r;
  logic              rd_vld_r;
  logic              proc_en_r;
  logic [SLOT_W-1:0] proc_addr_r;

  logic in_range;
  assign in_range = int'(item_r.slot_index) < NUM_SLOTS;

  assign rd_addr = (item_r.operation == OP_CHARGE) ? SLOT_W'(item_r.slot_index) : sweep_idx;

  assign stat.sweep_one  = (item_r.operation == OP_CHARGE);
  assign stat.sweep_none = (item_r.operation > OP_MAINT);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_row_r <= rows_mem[rd_addr];
      rd_rem_r <= rem_mem[rd_addr];
      rd_vld_r <= row_vld_r[rd_addr];
    end
    proc_addr_r <= rd_addr;
  end

  // Per-slot update, in the cycle after the memory read.
  row_t              cur;
  row_t              wr_row;
  logic              wr_en;
  logic              wr_rem_en;
  logic [REM_W-1:0]  wr_rem;
  logic              hit_set;
  logic              shell_set;
  logic              alloc_take;
  logic              charge_take;
  logic [LVL_W-1:0]  new_lvl;
  logic [LVL_W:0]    lvl_p1;
  logic [QU_W+LVL_W:0] quantum;

  always_comb begin
    cur         = rd_vld_r ? rd_row_r : '0;
    wr_row      = cur;
    wr_en       = 1'b0;
    wr_rem_en   = 1'b0;
    wr_rem      = rd_rem_r;
    hit_set     = 1'b0;
    shell_set   = 1'b0;
    alloc_take  = 1'b0;
    charge_take = 1'b0;
    new_lvl     = cur.level;
    lvl_p1      = '0;
    quantum     = '0;
    case (item_r.operation)
      OP_ALLOC: begin
        if (proc_en_r && !hit_r && cur.state == ST_UNUSED) begin
          wr_row.state = ST_LOADING;
          wr_row.pid   = pid_counter_r + 1'b1;
          wr_row.level = '0;
          wr_rem       = REM_W'(quantum_unit_r);
          wr_en        = 1'b1;
          wr_rem_en    = 1'b1;
          hit_set      = 1'b1;
          alloc_take   = 1'b1;
        end
      end
      OP_CHARGE: begin
        if (RT_W'(rd_rem_r) <= item_r.runtime_us) begin
          new_lvl = (cur.level < MAX_LVL) ? cur.level + 1'b1 : cur.level;
          lvl_p1  = {1'b0, new_lvl} + 1'b1;
          quantum = lvl_p1 * quantum_unit_r;
          wr_rem  = REM_W'(quantum);
        end else begin
          wr_rem  = rd_rem_r - REM_W'(item_r.runtime_us);
        end
        wr_row.level = new_lvl;
        if (proc_en_r && in_range) begin
          wr_en       = 1'b1;
          wr_rem_en   = 1'b1;
          charge_take = 1'b1;
        end
      end
      OP_SET: begin
        if (proc_en_r && cur.pid == item_r.target_pid) begin
          wr_row.state = item_r.new_status;
          wr_en        = 1'b1;
          hit_set      = 1'b1;
        end
      end
      OP_FREE: begin
        if (proc_en_r && cur.pid == item_r.target_pid && cur.state != ST_UNUSED) begin
          wr_row.state = ST_UNUSED;
          wr_en        = 1'b1;
          hit_set      = 1'b1;
        end
      end
      OP_FREE_ALL: begin
        if (proc_en_r && cur.state != ST_UNUSED && cur.pid >= first_user_pid_r) begin
          wr_row.state = ST_UNUSED;
          wr_en        = 1'b1;
        end
      end
      OP_MAINT: begin
        wr_row.level = '0;
        if (proc_en_r && item_r.tty_pending && !shell_done_r && cur.pid == shell_pid_r) begin
          wr_en     = 1'b1;
          shell_set = 1'b1;
        end
        if (proc_en_r && do_reset_r && cur.state != ST_UNUSED) begin
          wr_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows_mem[proc_addr_r] <= wr_row;
    end
    if (wr_rem_en) begin
      rem_mem[proc_addr_r] <= wr_rem;
    end
  end

  // Global reset timing, evaluated once per maintain item.
  logic [TIME_W-1:0] last_eff;
  logic [TIME_W-1:0] elapsed;
  logic              do_reset;

  assign last_eff = (last_reset_r == '0) ? item_r.now_us : last_reset_r;
  assign elapsed  = item_r.now_us - last_eff;
  assign do_reset = elapsed >= TIME_W'(reset_period_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r     <= '0;
      pid_counter_r <= '0;
      last_reset_r  <= '0;
      proc_en_r     <= 1'b0;
      do_reset_r    <= 1'b0;
      hit_r         <= 1'b0;
      shell_done_r  <= 1'b0;
    end else begin
      proc_en_r <= cmd.rd_en;
      if (wr_en) begin
        row_vld_r[proc_addr_r] <= 1'b1;
      end
      if (alloc_take) begin
        pid_counter_r <= pid_counter_r + 1'b1;
      end
      if (cmd.latch) begin
        hit_r        <= 1'b0;
        shell_done_r <= 1'b0;
        do_reset_r   <= 1'b0;
      end else begin
        if (hit_set) begin
          hit_r <= 1'b1;
        end
        if (shell_set) begin
          shell_done_r <= 1'b1;
        end
        if (cmd.prep && item_r.operation == OP_MAINT) begin
          do_reset_r   <= do_reset;
          last_reset_r <= do_reset ? item_r.now_us : last_eff;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
    if (alloc_take) begin
      res_slot_r <= GSLOT_W'(proc_addr_r);
    end
    if (charge_take) begin
      res_level_r <= new_lvl;
    end
  end

  out_item_t result;

  always_comb begin
    result = '0;
    case (item_r.operation)
      OP_ALLOC: begin
        if (hit_r) begin
          result.given_pid  = pid_counter_r;
          result.given_slot = res_slot_r;
        end else begin
          result.result_code = RC_FULL;
        end
      end
      OP_CHARGE: begin
        result.given_slot = item_r.slot_index;
        result.slot_level = in_range ? res_level_r : '0;
      end
      OP_SET, OP_FREE: begin
        result.result_code = hit_r ? RC_OK : RC_NOT_FOUND;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= result;
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== design/mlfq_process_table.sv =====
// MLFQ process table: slot status, pid, queue level and quantum accounting.
// A charge reads and updates only its own slot; alloc, set status, free, free all and maintain
// sweep the slot memory one slot a cycle. An undefined operation code skips the sweep.
// A new item is taken only once the previous result has been loaded into the result register.
// Reset (synchronous, active low) clears slot valid bits, pid counter and timing state
// and loads register defaults; it needs no clearing pass.
module mlfq_process_table #(
  parameter int NUM_SLOTS  = mlfq_pkg::DEF_NUM_SLOTS,
  parameter int NUM_LEVELS = mlfq_pkg::DEF_NUM_LEVELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mlfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mlfq_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mlfq_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mlfq_pkg::out_item_t            out_data
);
  import mlfq_pkg::*;

  dp_cmd_t                      cmd;
  dp_stat_t                     stat;
  logic [$clog2(NUM_SLOTS)-1:0] sweep_idx;

  mlfq_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .sweep_idx (sweep_idx)
  );

  mlfq_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sweep_idx (sweep_idx),
    .stat      (stat)
  );

endmodule

// ===== tb/sv/mlfq_process_table_tb.sv =====
// Self-checking testbench for the MLFQ process table (mlfq_process_table).
// Predicts every result from a shadow copy of the slot table and checks it in order.
// Depends on mlfq_pkg for the payload structs, operation codes and register indexes.
`timescale 1ns / 100ps

module mlfq_process_table_tb;
  import mlfq_pkg::*;

  localparam int NS = DEF_NUM_SLOTS;
  localparam int NL = DEF_NUM_LEVELS;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 200;

  // Operation codes outside the defined set; the block must ignore them.
  localparam logic [2:0] OP_UNKNOWN_A = 3'd6;
  localparam logic [2:0] OP_UNKNOWN_B = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  cfg_idx_e             cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;

  bit                   calm;
  int                   quiet_cycles = 0;

  class mlfq_shadow;
    logic [STAT_W-1:0] slot_status[NS];
    logic [PID_W-1:0]  slot_owner[NS];
    logic [LVL_W-1:0]  slot_lvl[NS];
    logic [31:0]       slot_left[NS];
    bit                slot_loaded[NS];
    logic [PID_W-1:0]  next_pid;
    logic [TIME_W-1:0] last_sweep;
    logic [QU_W-1:0]   unit;
    logic [RP_W-1:0]   period;
    logic [PID_W-1:0]  shell;
    logic [PID_W-1:0]  first_user;
    out_item_t         replies_due[$];
    int                mismatches;

    function new();
      foreach (slot_status[i]) begin
        slot_status[i] = ST_UNUSED;
        slot_owner[i]  = '0;
        slot_lvl[i]    = '0;
        slot_left[i]   = '0;
        slot_loaded[i] = 1'b0;
      end
      next_pid   = '0;
      last_sweep = '0;
      unit       = QU_RST;
      period     = RP_RST;
      shell      = SHELL_RST;
      first_user = FUP_RST;
      mismatches = 0;
    endfunction

    function void set_cfg(cfg_idx_e idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_QUANTUM_UNIT:   unit = v[QU_W-1:0];
        CFG_RESET_PERIOD:   period = v[RP_W-1:0];
        CFG_SHELL_PID:      shell = v[PID_W-1:0];
        CFG_FIRST_USER_PID: first_user = v[PID_W-1:0];
        default: ;
      endcase
    endfunction

    // Level n is worth n+1 quantum units.
    function logic [31:0] quantum(logic [LVL_W-1:0] lv);
      return (32'(lv) + 32'd1) * 32'(unit);
    endfunction

    function void note_request(in_item_t it);
      out_item_t         r;
      bit                hit;
      int                s;
      logic [TIME_W-1:0] gone;
      r   = '0;
      hit = 1'b0;
      s   = int'(it.slot_index);
      case (it.operation)
        OP_ALLOC: begin
          for (int i = 0; i < NS; i++) begin
            if (!hit && slot_status[i] == ST_UNUSED) begin
              hit            = 1'b1;
              next_pid       = next_pid + 1'b1;
              slot_owner[i]  = next_pid;
              slot_status[i] = ST_LOADING;
              slot_lvl[i]    = '0;
              slot_left[i]   = quantum('0);
              slot_loaded[i] = 1'b1;
              r.given_pid    = next_pid;
              r.given_slot   = GSLOT_W'(i);
            end
          end
          if (!hit) r.result_code = RC_FULL;
        end
        OP_CHARGE: begin
          r.given_slot = it.slot_index;
          if (32'(it.runtime_us) >= slot_left[s]) begin
            if (slot_lvl[s] < LVL_W'(NL - 1)) slot_lvl[s] = slot_lvl[s] + 1'b1;
            slot_left[s] = quantum(slot_lvl[s]);
          end else begin
            slot_left[s] = slot_left[s] - 32'(it.runtime_us);
          end
          r.slot_level = slot_lvl[s];
        end
        OP_SET: begin
          for (int i = 0; i < NS; i++) begin
            if (slot_owner[i] == it.target_pid) begin
              slot_status[i] = it.new_status;
              hit = 1'b1;
            end
          end
          if (!hit) r.result_code = RC_NOT_FOUND;
        end
        OP_FREE: begin
          for (int i = 0; i < NS; i++) begin
            if (slot_owner[i] == it.target_pid && slot_status[i] != ST_UNUSED) begin
              slot_status[i] = ST_UNUSED;
              hit = 1'b1;
            end
          end
          if (!hit) r.result_code = RC_NOT_FOUND;
        end
        OP_FREE_ALL: begin
          for (int i = 0; i < NS; i++)
            if (slot_status[i] != ST_UNUSED && slot_owner[i] >= first_user)
              slot_status[i] = ST_UNUSED;
        end
        OP_MAINT: begin
          // Only the lowest slot carrying the shell pid is boosted.
          if (it.tty_pending) begin
            for (int i = 0; i < NS; i++) begin
              if (!hit && slot_owner[i] == shell) begin
                slot_lvl[i] = '0;
                hit = 1'b1;
              end
            end
          end
          if (last_sweep == '0) last_sweep = it.now_us;
          gone = it.now_us - last_sweep;
          if (gone >= TIME_W'(period)) begin
            for (int i = 0; i < NS; i++)
              if (slot_status[i] != ST_UNUSED) slot_lvl[i] = '0;
            last_sweep = it.now_us;
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: code %0d pid %0d slot %0d level %0d",
                   got.result_code, got.given_pid, got.given_slot, got.slot_level);
      end else begin
        want = replies_due.pop_front();
        if (got.result_code !== want.result_code || got.given_pid !== want.given_pid ||
            got.given_slot !== want.given_slot || got.slot_level !== want.slot_level) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected code %0d pid %0d slot %0d level %0d,",
                      " got code %0d pid %0d slot %0d level %0d"},
                     want.result_code, want.given_pid, want.given_slot, want.slot_level,
                     got.result_code, got.given_pid, got.given_slot, got.slot_level);
        end
      end
    endfunction
  endclass

  mlfq_shadow shadow;

  mlfq_process_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.check_reply(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("mlfq_process_table_tb: errors");
      $finish;
    end
  end

  // Result side: hold off each transfer for a random number of cycles.
  initial begin
    int unsigned hold;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t random_fields(logic [2:0] op);
    in_item_t it;
    it.operation   = op;
    it.target_pid  = 16'($urandom);
    it.slot_index  = 4'($urandom);
    it.new_status  = 3'($urandom);
    it.runtime_us  = 24'($urandom);
    it.now_us      = {16'($urandom), 32'($urandom)};
    it.tty_pending = 1'($urandom);
    return it;
  endfunction

  // Charges only ever target slots that an alloc has loaded with a quantum.
  function automatic in_item_t next_item();
    in_item_t    it;
    int unsigned pick;
    int          loaded[$];
    int          s;
    logic [31:0] left;
    logic [63:0] span;
    pick = $urandom_range(0, 99);
    foreach (shadow.slot_loaded[i]) if (shadow.slot_loaded[i]) loaded.push_back(i);
    if (pick < 25 || (pick < 55 && loaded.size() == 0)) begin
      it = random_fields(OP_ALLOC);
    end else if (pick < 55) begin
      it = random_fields(OP_CHARGE);
      s = loaded[$urandom_range(0, loaded.size() - 1)];
      left = shadow.slot_left[s];
      it.slot_index = 4'(s);
      case ($urandom_range(0, 4))
        0: it.runtime_us = 24'(left - 1);
        1: it.runtime_us = 24'(left);
        2: it.runtime_us = 24'($urandom_range(0, left));
        3: it.runtime_us = 24'($urandom_range(0, 255));
        default: ;
      endcase
    end else if (pick < 80) begin
      it = random_fields(pick < 67 ? OP_SET : OP_FREE);
      case ($urandom_range(0, 9))
        7: it.target_pid = shadow.shell;
        8, 9: ;
        default: it.target_pid = shadow.slot_owner[$urandom_range(0, NS - 1)];
      endcase
    end else if (pick < 83) begin
      it = random_fields(OP_FREE_ALL);
    end else if (pick < 95) begin
      it = random_fields(OP_MAINT);
      span = 64'(shadow.period);
      case ($urandom_range(0, 5))
        0: it.now_us = shadow.last_sweep + TIME_W'(span);
        1: it.now_us = shadow.last_sweep + TIME_W'(span - 1);
        2: it.now_us = shadow.last_sweep + TIME_W'({$urandom, $urandom} % (2 * span + 1));
        3: it.now_us = '0;
        4: it.now_us = shadow.last_sweep;
        default: ;
      endcase
    end else begin
      it = random_fields($urandom_range(0, 1) ? OP_UNKNOWN_A : OP_UNKNOWN_B);
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    shadow.note_request(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    shadow.set_cfg(idx, v);
  endtask

  task automatic load_regs(logic [CFG_W-1:0] unit, logic [CFG_W-1:0] period,
                           logic [CFG_W-1:0] shell, logic [CFG_W-1:0] first_user);
    wait_idle();
    put_reg(CFG_QUANTUM_UNIT, unit);
    put_reg(CFG_RESET_PERIOD, period);
    put_reg(CFG_SHELL_PID, shell);
    put_reg(CFG_FIRST_USER_PID, first_user);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int p);
    logic [RP_W-1:0]  rp;
    logic [PID_W-1:0] owner;
    rp = {8'($urandom_range(0, 255)), 32'($urandom)};
    if (rp == '0) rp = 40'd1;
    owner = shadow.slot_owner[$urandom_range(0, NS - 1)];
    case (p)
      0: load_regs(40'(QU_RST), 40'(RP_RST), 40'(SHELL_RST), 40'(FUP_RST));
      1: load_regs(40'd1, 40'd1, 40'd0, 40'd0);
      2: load_regs(40'd1000000, '1, 40'hFFFF, 40'hFFFF);
      3: load_regs(40'($urandom_range(1, 1000000)), rp, 40'(owner),
                   40'($urandom_range(0, 64)));
      4: load_regs(40'($urandom_range(1, 2000)), 40'($urandom_range(1, 100000)),
                   40'(owner), 40'($urandom_range(0, 32)));
      5: load_regs(40'd1, '1, 40'(owner), 40'hFFFF);
      6: load_regs(40'($urandom_range(1, 1000000)), rp, 40'(owner),
                   40'($urandom_range(0, 65535)));
      default: load_regs(40'(QU_RST), 40'(RP_RST), 40'(SHELL_RST), 40'(FUP_RST));
    endcase
    calm = (p % 3 == 1);
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 49) == 0) wait_idle();
      send_item(next_item());
    end
  endtask

  initial begin
    in_item_t it;
    int       rounds;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_QUANTUM_UNIT;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    calm      = 1'b0;
    shadow    = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset register values.
    it = random_fields(OP_MAINT);
    it.now_us = '0;
    it.tty_pending = 1'b0;
    send_item(it);
    repeat (4) send_item(random_fields(OP_ALLOC));
    it = random_fields(OP_CHARGE);
    it.slot_index = 4'd0;
    it.runtime_us = '0;
    send_item(it);
    it.runtime_us = '1;
    send_item(it);
    it.slot_index = 4'd1;
    it.runtime_us = 24'd100000;
    send_item(it);
    it.runtime_us = 24'd199999;
    send_item(it);
    it.slot_index = 4'd3;
    it.runtime_us = '1;
    send_item(it);
    it = random_fields(OP_SET);
    it.target_pid = 16'd3;
    it.new_status = 3'd7;
    send_item(it);
    it.target_pid = '1;
    it.new_status = 3'd2;
    send_item(it);
    // Pid zero matches every slot that was never allocated.
    it.target_pid = '0;
    it.new_status = 3'd5;
    send_item(it);
    it = random_fields(OP_FREE);
    it.target_pid = '0;
    send_item(it);
    it.target_pid = 16'd2;
    send_item(it);
    send_item(it);
    send_item(random_fields(OP_ALLOC));
    send_item(random_fields(OP_FREE_ALL));
    it = random_fields(OP_CHARGE);
    it.slot_index = 4'd1;
    it.runtime_us = 24'd1;
    send_item(it);
    it = random_fields(OP_MAINT);
    it.tty_pending = 1'b1;
    it.now_us = 48'd1000;
    send_item(it);
    it.tty_pending = 1'b0;
    it.now_us = 48'd1000 + 48'(RP_RST) - 48'd1;
    send_item(it);
    it.now_us = 48'd1000 + 48'(RP_RST);
    send_item(it);
    // Time going backwards wraps the elapsed time to a huge value.
    it.now_us = 48'd5;
    send_item(it);
    send_item(random_fields(OP_UNKNOWN_A));
    send_item(random_fields(OP_UNKNOWN_B));

    for (int p = 0; p < 4; p++) run_phase(p);

    // Free everything, then fill the table and hit the full case once per round.
    load_regs(40'd1000, 40'(RP_RST), 40'(SHELL_RST), 40'd0);
    calm = 1'b1;
    rounds = 2;
    repeat (rounds) begin
      send_item(random_fields(OP_FREE_ALL));
      repeat (NS + 1) send_item(random_fields(OP_ALLOC));
    end

    for (int p = 4; p < 8; p++) run_phase(p);

    wait_idle();
    repeat (25) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("mlfq_process_table_tb: clean");
    end else begin
      $display("mlfq_process_table_tb: errors");
    end
    $finish;
  end

endmodule
